// ===== hw/rtl/rme_pkg.sv =====
// Shared types and constants of the modular exponentiation unit.
// No dependencies; imported by the register file, the multiplier and the top level.
package rme_pkg;

  // Register index width and register indexes on the configuration port
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_MODULUS     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PUBLIC_EXP  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PRIVATE_EXP = 2'd2;

  // Command codes of an input request
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // Status of the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// ===== hw/rtl/rme_regs.sv =====
// Configuration register file: modulus and the two exponents behind an APB-style port.
// Depends on rme_pkg for the register indexes.
module rme_regs #(
  parameter int WORD_WIDTH = 32,
  parameter int DATA_W     = 32,
  parameter int ADDR_W     = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic [WORD_WIDTH-1:0] modulus,
  output logic [WORD_WIDTH-1:0] public_exponent,
  output logic [WORD_WIDTH-1:0] private_exponent
);
  import rme_pkg::*;

  localparam int ALIGN = (DATA_W > 32) ? 3 : 2;

  logic [REG_IDX_W-1:0]  idx;
  logic                  wr_en;
  logic [WORD_WIDTH-1:0] wr_val;

  assign idx    = paddr[ADDR_W-1:ALIGN];
  assign wr_en  = psel && penable && pwrite;
  assign wr_val = pwdata[WORD_WIDTH-1:0];

  // Write the addressed register; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= WORD_WIDTH'(2);
      public_exponent  <= '0;
      private_exponent <= '0;
    end else if (wr_en) begin
      if (idx == REG_MODULUS)     modulus          <= wr_val;
      if (idx == REG_PUBLIC_EXP)  public_exponent  <= wr_val;
      if (idx == REG_PRIVATE_EXP) private_exponent <= wr_val;
    end
  end

  // Return the addressed register, zero beyond the list
  always_comb begin
    prdata = '0;
    if (idx == REG_MODULUS)     prdata = DATA_W'(modulus);
    if (idx == REG_PUBLIC_EXP)  prdata = DATA_W'(public_exponent);
    if (idx == REG_PRIVATE_EXP) prdata = DATA_W'(private_exponent);
  end

endmodule

// ===== hw/rtl/rme_mod_mul.sv =====
// Shared iterative modular multiplier: (a * b) mod m by shift-and-add, one bit of b a cycle.
// Depends on rme_pkg for the status struct. Requires a < m; b may take any value.
module rme_mod_mul #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [WORD_WIDTH-1:0] a,
  input  logic [WORD_WIDTH-1:0] b,
  input  logic [WORD_WIDTH-1:0] m,
  output logic [WORD_WIDTH-1:0] product,
  output rme_pkg::mul_stat_t    status
);
  import rme_pkg::*;

  localparam int CW = $clog2(WORD_WIDTH);
  localparam logic [CW-1:0] LAST = CW'(WORD_WIDTH - 1);

  logic [WORD_WIDTH-1:0] acc;
  logic [WORD_WIDTH-1:0] addend;
  logic [WORD_WIDTH-1:0] mult;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic                  done;
  logic [WORD_WIDTH-1:0] acc_next;
  logic [WORD_WIDTH-1:0] addend_next;

  // (x + y) mod m for x, y below m, without a carry out of the word
  function automatic logic [WORD_WIDTH-1:0] add_mod(input logic [WORD_WIDTH-1:0] x,
                                                    input logic [WORD_WIDTH-1:0] y,
                                                    input logic [WORD_WIDTH-1:0] md);
    logic [WORD_WIDTH-1:0] room;
    room = md - y;
    if (x >= room) return x - room;
    return x + y;
  endfunction

  // Two independent modular adders: accumulate and double
  assign acc_next    = mult[0] ? add_mod(acc, addend, m) : acc;
  assign addend_next = add_mod(addend, addend, m);

  // Control: run one step per cycle over every bit of b
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then advance one bit of b
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      addend <= a;
      mult   <= b;
    end else if (busy) begin
      acc    <= acc_next;
      addend <= addend_next;
      mult   <= mult >> 1;
    end
  end

  assign product     = acc;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== hw/rtl/rsa_modular_exponentiation_unit.sv =====
// RSA modular exponentiation unit: top level with the square-and-multiply sequencer.
// Depends on rme_pkg, rme_regs and rme_mod_mul.
//
// Each request (command, operand_value) yields operand_value raised to the public
// exponent (command 0) or private exponent (command 1) modulo the configured modulus;
// an exponent of zero gives 1 and a modulus below 2 gives 0. One shared modular
// multiplier, which consumes one multiplier bit per cycle, sets the pace: the operand
// is first reduced, then each exponent bit costs one squaring and, when the bit is
// set, one multiplication; the squaring after the highest set bit is skipped. A new
// request is not taken until the last one is through: the unit holds in_stall high
// for the whole of a request; a finished result waits in the output register while
// the next request is taken. The user must write configuration only while the unit
// is idle; the unit itself does not enforce this.
module rsa_modular_exponentiation_unit #(
  parameter int WORD_WIDTH = 32,
  localparam int DATA_W = (WORD_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_W = ((WORD_WIDTH > 32) ? 3 : 2) + rme_pkg::REG_IDX_W
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  command,
  input  logic [WORD_WIDTH-1:0] operand_value,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WORD_WIDTH-1:0] result_value
);
  import rme_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_TEST   = 3'd2;
  localparam logic [2:0] S_MULT   = 3'd3;
  localparam logic [2:0] S_SQUARE = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]            state;
  logic [WORD_WIDTH-1:0] base;
  logic [WORD_WIDTH-1:0] acc;
  logic [WORD_WIDTH-1:0] expo;
  logic [WORD_WIDTH-1:0] modulus;
  logic [WORD_WIDTH-1:0] public_exponent;
  logic [WORD_WIDTH-1:0] private_exponent;
  logic                  in_accept;
  logic                  out_free;
  logic                  mod_ok;
  logic                  mul_start;
  logic [WORD_WIDTH-1:0] mul_a;
  logic [WORD_WIDTH-1:0] mul_b;
  logic [WORD_WIDTH-1:0] mul_product;
  mul_stat_t             mul_status;

  rme_regs #(
    .WORD_WIDTH(WORD_WIDTH),
    .DATA_W    (DATA_W),
    .ADDR_W    (ADDR_W)
  ) u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .modulus         (modulus),
    .public_exponent (public_exponent),
    .private_exponent(private_exponent)
  );

  assign pready = 1'b1;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign mod_ok    = (modulus >= WORD_WIDTH'(2));

  // Start the multiplier on reduction, multiply or square
  assign mul_start = (in_accept && mod_ok) || ((state == S_TEST) && (expo != '0));

  // Operand selection: reduction is 1 * value, then acc * base or base * base
  always_comb begin
    if (state == S_IDLE) begin
      mul_a = WORD_WIDTH'(1);
      mul_b = operand_value;
    end else if (expo[0]) begin
      mul_a = acc;
      mul_b = base;
    end else begin
      mul_a = base;
      mul_b = base;
    end
  end

  rme_mod_mul #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .m      (modulus),
    .product(mul_product),
    .status (mul_status)
  );

  // Output register: load on finish, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= (state == S_FINISH);
    end
  end

  // Sequencer: reduce, then walk the exponent from its low bit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            expo  <= (command == CMD_DECRYPT) ? private_exponent : public_exponent;
            acc   <= mod_ok ? WORD_WIDTH'(1) : '0;
            state <= mod_ok ? S_REDUCE : S_FINISH;
          end
        end
        S_REDUCE: begin
          if (mul_status.done) begin
            base  <= mul_product;
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (expo == '0) begin
            state <= S_FINISH;
          end else if (expo[0]) begin
            state <= S_MULT;
          end else begin
            expo  <= expo >> 1;
            state <= S_SQUARE;
          end
        end
        S_MULT: begin
          if (mul_status.done) begin
            acc     <= mul_product;
            expo[0] <= 1'b0;
            state   <= S_TEST;
          end
        end
        S_SQUARE: begin
          if (mul_status.done) begin
            base  <= mul_product;
            state <= S_TEST;
          end
        end
        S_FINISH: begin
          // Hold until the output register is free
          if (out_free) begin
            result_value <= acc;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== test/tb_rsa_modular_exponentiation_unit.sv =====
// Self-checking testbench for the RSA modular exponentiation unit.
// Depends on rme_pkg and rsa_modular_exponentiation_unit; writes the keys over the
// register port, streams requests with random gaps and stalls, and compares results.
module tb_rsa_modular_exponentiation_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rme_pkg::*;

  localparam int WORD_WIDTH = 32;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 2 + REG_IDX_W;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int NUM_PHASES = 11;
  localparam int PER_PHASE = 23;
  localparam int DRAIN_CYCLES = 2300;

  // Where the expected result of a directed row comes from
  localparam logic FROM_MODEL = 1'b0;
  localparam logic FROM_TABLE = 1'b1;

  typedef logic [WORD_WIDTH-1:0] word_t;

  typedef struct packed {
    word_t modulus;
    word_t pub_exp;
    word_t priv_exp;
    logic  cmd;
    word_t operand;
    logic  source;
    word_t result;
  } vector_t;

  typedef struct {
    word_t value;
    int    serial;
  } pending_t;

  // Directed requests: key setting, request and, where obvious, the result
  localparam int NUM_VECTORS = 24;
  localparam vector_t VECTORS [NUM_VECTORS] = '{
    // reset keys, exponent zero
    '{32'd2, 32'd0, 32'd0, CMD_ENCRYPT, 32'd0, FROM_TABLE, 32'd1},
    '{32'd2, 32'd0, 32'd0, CMD_DECRYPT, 32'hffff_ffff, FROM_TABLE, 32'd1},
    // modulus zero and one give zero whatever the exponent
    '{32'd0, 32'd5, 32'd7, CMD_ENCRYPT, 32'd12345, FROM_TABLE, 32'd0},
    '{32'd0, 32'd5, 32'd7, CMD_DECRYPT, 32'hffff_ffff, FROM_TABLE, 32'd0},
    '{32'd0, 32'd0, 32'd0, CMD_ENCRYPT, 32'd3, FROM_TABLE, 32'd0},
    '{32'd1, 32'hffff_ffff, 32'd0, CMD_ENCRYPT, 32'd77, FROM_TABLE, 32'd0},
    '{32'd1, 32'hffff_ffff, 32'd0, CMD_DECRYPT, 32'd77, FROM_TABLE, 32'd0},
    // smallest legal modulus, largest exponents
    '{32'd2, 32'hffff_ffff, 32'hffff_ffff, CMD_ENCRYPT, 32'd3, FROM_TABLE, 32'd1},
    '{32'd2, 32'hffff_ffff, 32'hffff_ffff, CMD_DECRYPT, 32'hffff_ffff, FROM_TABLE, 32'd1},
    '{32'd2, 32'hffff_ffff, 32'hffff_ffff, CMD_ENCRYPT, 32'hffff_fffe, FROM_TABLE, 32'd0},
    // largest modulus: operand equal to it, identity exponent, minus one squared
    '{32'hffff_ffff, 32'd1, 32'd2, CMD_ENCRYPT, 32'hffff_ffff, FROM_TABLE, 32'd0},
    '{32'hffff_ffff, 32'd1, 32'd2, CMD_ENCRYPT, 32'h1234_5678, FROM_TABLE, 32'h1234_5678},
    '{32'hffff_ffff, 32'd1, 32'd2, CMD_DECRYPT, 32'hffff_fffe, FROM_TABLE, 32'd1},
    '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, CMD_ENCRYPT, 32'hffff_fffe,
      FROM_TABLE, 32'hffff_fffe},
    '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, CMD_DECRYPT, 32'd0, FROM_TABLE, 32'd0},
    '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, CMD_ENCRYPT, 32'd1, FROM_TABLE, 32'd1},
    '{32'hffff_ffff, 32'hffff_ffff, 32'd0, CMD_DECRYPT, 32'hdead_beef, FROM_TABLE, 32'd1},
    // textbook key pair, operand above the modulus
    '{32'd3233, 32'd17, 32'd2753, CMD_ENCRYPT, 32'd65, FROM_MODEL, 32'd0},
    '{32'd3233, 32'd17, 32'd2753, CMD_DECRYPT, 32'd2790, FROM_MODEL, 32'd0},
    '{32'd3233, 32'd17, 32'd2753, CMD_ENCRYPT, 32'hffff_ffff, FROM_MODEL, 32'd0},
    // large prime modulus and a power-of-two modulus
    '{32'hffff_fffb, 32'h0001_0001, 32'hffff_fffe, CMD_ENCRYPT, 32'h8000_0000,
      FROM_MODEL, 32'd0},
    '{32'hffff_fffb, 32'h0001_0001, 32'hffff_fffe, CMD_DECRYPT, 32'hdead_beef,
      FROM_MODEL, 32'd0},
    '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, CMD_ENCRYPT, 32'd3, FROM_MODEL, 32'd0},
    '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, CMD_DECRYPT, 32'haaaa_aaaa,
      FROM_MODEL, 32'd0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              command = CMD_ENCRYPT;
  word_t             operand_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  word_t             result_value;

  // Key registers as the unit should hold them, indexed by register index
  word_t    key_regs [3] = '{32'd2, 32'd0, 32'd0};
  pending_t pending_results [$];
  pending_t arrived;
  logic     rx_quiet = 1'b0;
  int       stall_left = 0;
  int       mismatches = 0;
  int       requests_sent = 0;
  int       decrypt_count = 0;
  int       results_checked = 0;
  int       register_writes = 0;
  int       key_settings = 0;

  rsa_modular_exponentiation_unit #(.WORD_WIDTH(WORD_WIDTH)) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .operand_value(operand_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_value(result_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Square-and-multiply over double-width products
  function automatic word_t mod_power(word_t base, word_t exponent, word_t modulus);
    logic [2*WORD_WIDTH-1:0] acc;
    logic [2*WORD_WIDTH-1:0] sq;
    logic [2*WORD_WIDTH-1:0] m;
    word_t                   bits;
    if (modulus < 2) return '0;
    m = (2*WORD_WIDTH)'(modulus);
    acc = (2*WORD_WIDTH)'(1);
    sq = (2*WORD_WIDTH)'(base) % m;
    bits = exponent;
    while (bits != 0) begin
      if (bits[0]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
      bits = bits >> 1;
    end
    return acc[WORD_WIDTH-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  // One register transfer: setup cycle, then access cycle until pready
  task automatic register_access(input logic write, input logic [REG_IDX_W-1:0] idx,
                                 input word_t wdata, output word_t rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (write) begin
      register_writes++;
      if (idx <= REG_PRIVATE_EXP) key_regs[idx] = wdata;
    end
  endtask

  // Read every key register back, then release the bus
  task automatic verify_registers();
    word_t readback;
    for (int i = 0; i <= REG_PRIVATE_EXP; i++) begin
      register_access(1'b0, REG_IDX_W'(i), '0, readback);
      if (readback !== key_regs[i])
        report_mismatch($sformatf("register %0d reads %h, expected %h",
                                  i, readback, key_regs[i]));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_keys(input word_t modulus, input word_t pub_exp, input word_t priv_exp);
    word_t unused;
    register_access(1'b1, REG_MODULUS, modulus, unused);
    register_access(1'b1, REG_PUBLIC_EXP, pub_exp, unused);
    register_access(1'b1, REG_PRIVATE_EXP, priv_exp, unused);
    verify_registers();
    key_settings++;
  endtask

  // Present one request after a gap, hold it until taken, record its expected result
  task automatic issue_request(input logic cmd, input word_t operand, input int gap,
                               input logic source, input word_t table_result);
    pending_t entry;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    operand_value <= operand;
    do @(posedge clk); while (in_stall);
    if (source == FROM_TABLE) begin
      entry.value = table_result;
    end else begin
      entry.value = mod_power(operand, (cmd == CMD_DECRYPT) ? key_regs[REG_PRIVATE_EXP]
                                                            : key_regs[REG_PUBLIC_EXP],
                              key_regs[REG_MODULUS]);
    end
    entry.serial = requests_sent;
    pending_results = {pending_results, entry};
    requests_sent++;
    if (cmd == CMD_DECRYPT) decrypt_count++;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic word_t random_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return word_t'($urandom_range(0, 15));
      3: return word_t'(1) << $urandom_range(0, WORD_WIDTH - 1);
      default: return $urandom;
    endcase
  endfunction

  // Bias operands towards the modulus and the edges of the range
  function automatic word_t pick_operand();
    case ($urandom_range(0, 7))
      0: return key_regs[REG_MODULUS] - 1;
      1: return key_regs[REG_MODULUS] + $urandom_range(0, 3);
      2: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      3: return word_t'($urandom_range(0, 255));
      default: return random_word();
    endcase
  endfunction

  // Mostly short gaps, some medium, a few long
  function automatic int pick_gap(input logic quiet);
    if (quiet) return 0;
    case ($urandom_range(0, 19))
      0: return $urandom_range(20, 150);
      1, 2, 3, 4, 5: return $urandom_range(3, 10);
      default: return $urandom_range(0, 2);
    endcase
  endfunction

  // Result side: check each accepted result, then choose the next stall run
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h arrived with no request outstanding",
                                  result_value));
      end else begin
        arrived = pending_results.pop_front();
        results_checked++;
        if (result_value !== arrived.value)
          report_mismatch($sformatf("request %0d: result %h, expected %h",
                                    arrived.serial, result_value, arrived.value));
      end
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (rx_quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 300)
                                                  : $urandom_range(0, 3);
    end
  end

  initial begin
    word_t scratch;
    logic  quiet;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    verify_registers();

    // Directed part: change keys only where the row asks for other ones
    for (int i = 0; i < NUM_VECTORS; i++) begin
      if (VECTORS[i].modulus != key_regs[REG_MODULUS] ||
          VECTORS[i].pub_exp != key_regs[REG_PUBLIC_EXP] ||
          VECTORS[i].priv_exp != key_regs[REG_PRIVATE_EXP])
        load_keys(VECTORS[i].modulus, VECTORS[i].pub_exp, VECTORS[i].priv_exp);
      issue_request(VECTORS[i].cmd, VECTORS[i].operand, $urandom_range(0, 3),
                    VECTORS[i].source, VECTORS[i].result);
      in_valid <= 1'b0;
      wait_drained();
    end

    // A write past the last register must leave the keys alone
    register_access(1'b1, REG_UNUSED, $urandom, scratch);
    verify_registers();

    // Random part: one key setting per phase, streamed requests
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      quiet = ($urandom_range(0, 3) == 0);
      rx_quiet <= quiet;
      load_keys(random_word(), random_word(), random_word());
      for (int n = 0; n < PER_PHASE; n++)
        issue_request(logic'($urandom_range(0, 1)), pick_operand(), pick_gap(quiet),
                      FROM_MODEL, '0);
      in_valid <= 1'b0;
      wait_drained();
    end

    // Allow any stray result to surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d requests (%0d decrypt) under %0d key settings, %0d register writes.",
             requests_sent, decrypt_count, key_settings, register_writes);
    $display("Compared %0d results, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
